// ===== rtl/lgre_pkg.sv =====
// Shared types, constants and cell-rule helpers for the Life row engine.
package lgre_pkg;

	// Fixed field widths
	localparam int ROW_W    = 64;
	localparam int GRID_W_W = 7;

	// Defaults for top-level parameters
	localparam int MAX_WIDTH_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 3;

	// B3/S23 neighbor counts
	localparam int BIRTH_COUNT   = 3;
	localparam int SURVIVE_COUNT = 2;

	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [GRID_W_W-1:0] grid_w_t;

	// Per-entry control passed from front to back
	typedef struct packed {
		logic two;   // entry yields two result rows (bottom of a multi-row grid)
		logic done;  // first result of the entry is the grid bottom
	} ctl_t;

	// Bit j set when cell j lies inside a grid of width w
	function automatic row_t width_mask(input grid_w_t w);
		row_t m;
		for (int j = 0; j < ROW_W; j++) begin
			m[j] = (GRID_W_W'(j) < w);
		end
		return m;
	endfunction

	// Next state of one cell from its 3x3 window, bit 1 of mid is the cell itself
	function automatic logic cell_next(input logic [2:0] up, input logic [2:0] mid,
			input logic [2:0] down);
		logic [3:0] n;
		n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
			+ 4'(down[0]) + 4'(down[1]) + 4'(down[2]);
		return (n == 4'(BIRTH_COUNT)) || (mid[1] && (n == 4'(SURVIVE_COUNT)));
	endfunction

endpackage

// ===== rtl/lgre_if.sv =====
// Channel interfaces: input rows, result rows and the width register write.

interface lgre_row_in_if;
	logic                valid;
	logic                ready;
	logic [lgre_pkg::ROW_W-1:0] row_cells;
	logic                last_row;

	modport source (output valid, output row_cells, output last_row, input ready);
	modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface lgre_row_out_if;
	logic                valid;
	logic                ready;
	logic [lgre_pkg::ROW_W-1:0] next_row_cells;
	logic                grid_done;

	modport source (output valid, output next_row_cells, output grid_done, input ready);
	modport sink   (input valid, input next_row_cells, input grid_done, output ready);
endinterface

interface lgre_cfg_if;
	logic                   valid;
	logic                   ready;
	logic [lgre_pkg::GRID_W_W-1:0] grid_width;

	modport source (output valid, output grid_width, input ready);
	modport sink   (input valid, input grid_width, output ready);
endinterface

// ===== rtl/lgre_front.sv =====
// Front end: takes row beats, holds the two previous rows, queues work entries.
module lgre_front #(
	parameter int MAX_WIDTH = lgre_pkg::MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lgre_row_in_if.sink          row_in,
	lgre_cfg_if.sink             cfg,
	input  logic                 push_ready,
	output logic                 push_valid,
	output logic [MAX_WIDTH-1:0] push_up,
	output logic [MAX_WIDTH-1:0] push_mid,
	output logic [MAX_WIDTH-1:0] push_down,
	output lgre_pkg::ctl_t       push_ctl,
	output logic [MAX_WIDTH-1:0] mask
);
	import lgre_pkg::*;

	logic [MAX_WIDTH-1:0] mask_q;
	logic [MAX_WIDTH-1:0] above_q;
	logic [MAX_WIDTH-1:0] middle_q;
	logic                 held_q;
	logic [MAX_WIDTH-1:0] cur;
	row_t                 new_mask;
	logic                 accept;

	// Width register kept as a cell mask, clamped to MAX_WIDTH by truncation
	assign cfg.ready = 1'b1;
	assign new_mask  = width_mask(cfg.grid_width);
	assign mask      = mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '1;
		end else if (cfg.valid) begin
			mask_q <= new_mask[MAX_WIDTH-1:0];
		end
	end

	// Accept and classify
	assign row_in.ready = push_ready;
	assign accept       = row_in.valid && push_ready;
	assign cur          = row_in.row_cells[MAX_WIDTH-1:0] & mask_q;
	assign push_valid   = accept && (held_q || row_in.last_row);

	always_comb begin
		if (held_q) begin
			push_up       = above_q;
			push_mid      = middle_q;
			push_down     = cur;
			push_ctl.two  = row_in.last_row;
			push_ctl.done = 1'b0;
		end else begin
			// single-row grid
			push_up       = '0;
			push_mid      = cur;
			push_down     = '0;
			push_ctl.two  = 1'b0;
			push_ctl.done = 1'b1;
		end
	end

	// Row history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q  <= '0;
			middle_q <= '0;
			held_q   <= 1'b0;
		end else if (accept) begin
			if (row_in.last_row) begin
				above_q  <= '0;
				middle_q <= '0;
				held_q   <= 1'b0;
			end else begin
				above_q  <= held_q ? middle_q : '0;
				middle_q <= cur;
				held_q   <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/lgre_queue.sv =====
// Small register FIFO between front and back.
module lgre_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = lgre_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              push_ready,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/lgre_back.sv =====
// Back end: applies B3/S23 to a queued row window and drives the result register.
module lgre_back #(
	parameter int MAX_WIDTH = lgre_pkg::MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  logic [MAX_WIDTH-1:0] head_up,
	input  logic [MAX_WIDTH-1:0] head_mid,
	input  logic [MAX_WIDTH-1:0] head_down,
	input  lgre_pkg::ctl_t       head_ctl,
	input  logic [MAX_WIDTH-1:0] mask,
	output logic                 pop,
	lgre_row_out_if.source       row_out
);
	import lgre_pkg::*;

	logic                 phase_q;
	logic                 out_valid_q;
	row_t                 out_cells_q;
	logic                 out_done_q;
	logic [MAX_WIDTH+1:0] pad_up;
	logic [MAX_WIDTH+1:0] pad_mid;
	logic [MAX_WIDTH+1:0] pad_down;
	logic [MAX_WIDTH-1:0] nxt;
	logic                 load;

	// Second pass of a bottom entry shifts the window down one row
	always_comb begin
		if (phase_q) begin
			pad_up   = {1'b0, head_mid, 1'b0};
			pad_mid  = {1'b0, head_down, 1'b0};
			pad_down = '0;
		end else begin
			pad_up   = {1'b0, head_up, 1'b0};
			pad_mid  = {1'b0, head_mid, 1'b0};
			pad_down = {1'b0, head_down, 1'b0};
		end
	end

	// One cell per lane, dead border outside the row
	for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_cell
		assign nxt[j] = cell_next(pad_up[j+2:j], pad_mid[j+2:j], pad_down[j+2:j]);
	end

	assign load = head_valid && (!out_valid_q || row_out.ready);
	assign pop  = load && (!head_ctl.two || phase_q);

	// Result register and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= head_ctl.two && !phase_q;
				out_valid_q <= 1'b1;
			end else if (row_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_cells_q <= ROW_W'(nxt & mask);
			out_done_q  <= phase_q || head_ctl.done;
		end
	end

	assign row_out.valid          = out_valid_q;
	assign row_out.next_row_cells = out_cells_q;
	assign row_out.grid_done      = out_done_q;

endmodule

// ===== rtl/life_generation_row_engine_unit.sv =====
// Top level of the Conway Life (B3/S23) row engine.
// Rows of a grid stream in top to bottom, one beat per row, and the block
// streams out the next generation of the same grid, one beat per row, in
// the same order; grid_done marks the bottom result row. Cells outside
// the grid are dead, with no wrap, and bits at or above the configured
// grid_width (clamped to MAX_WIDTH) are ignored on input and zero on
// output. The first row of a grid gives no result, a middle row gives the
// result for the row above it, and the bottom row gives the last two
// results (one for a single-row grid). An input beat can be taken every
// cycle while the queue has room, and its result passes through the
// queue and the result register. The back end retires one result per cycle
// while row_out is ready; the QUEUE_DEPTH-entry queue absorbs the extra
// result of a bottom row. Write grid_width only while the block is idle.
module life_generation_row_engine_unit #(
	parameter int MAX_WIDTH   = lgre_pkg::MAX_WIDTH_DEF,
	parameter int QUEUE_DEPTH = lgre_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	lgre_row_in_if.sink    row_in,
	lgre_row_out_if.source row_out,
	lgre_cfg_if.sink       cfg
);
	import lgre_pkg::*;

	localparam int ENTRY_W = 3 * MAX_WIDTH + $bits(ctl_t);

	logic                 push_valid;
	logic                 push_ready;
	logic [MAX_WIDTH-1:0] push_up;
	logic [MAX_WIDTH-1:0] push_mid;
	logic [MAX_WIDTH-1:0] push_down;
	ctl_t                 push_ctl;
	logic [MAX_WIDTH-1:0] mask;
	logic [ENTRY_W-1:0]   push_entry;
	logic [ENTRY_W-1:0]   head_entry;
	logic                 head_valid;
	logic                 pop;
	logic [MAX_WIDTH-1:0] head_up;
	logic [MAX_WIDTH-1:0] head_mid;
	logic [MAX_WIDTH-1:0] head_down;
	ctl_t                 head_ctl;

	lgre_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_in     (row_in),
		.cfg        (cfg),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_up    (push_up),
		.push_mid   (push_mid),
		.push_down  (push_down),
		.push_ctl   (push_ctl),
		.mask       (mask)
	);

	assign push_entry = {push_up, push_mid, push_down, push_ctl};

	lgre_queue #(
		.DATA_W (ENTRY_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_data  (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_entry)
	);

	assign {head_up, head_mid, head_down, head_ctl} = head_entry;

	lgre_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_up    (head_up),
		.head_mid   (head_mid),
		.head_down  (head_down),
		.head_ctl   (head_ctl),
		.mask       (mask),
		.pop        (pop),
		.row_out    (row_out)
	);

endmodule

// ===== rtl/lgre_checker.sv =====
// Port-level checks for the Life row engine, bound to the top level.
module lgre_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         in_last,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [lgre_pkg::ROW_W-1:0]   out_cells,
	input logic                         out_done,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [lgre_pkg::GRID_W_W-1:0] cfg_width
);
	import lgre_pkg::*;

	grid_w_t     width_q;
	logic [31:0] in_cnt_q;
	logic [31:0] out_cnt_q;
	logic [31:0] last_cnt_q;
	logic [31:0] done_cnt_q;
	row_t        live_mask;
	logic        in_beat;
	logic        out_beat;

	assign in_beat   = in_valid && in_ready;
	assign out_beat  = out_valid && out_ready;
	assign live_mask = width_mask(width_q);

	// Shadow width and beat tallies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= GRID_W_W'(ROW_W);
			in_cnt_q   <= '0;
			out_cnt_q  <= '0;
			last_cnt_q <= '0;
			done_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				width_q <= cfg_width;
			end
			if (in_beat) begin
				in_cnt_q <= in_cnt_q + 1'b1;
				if (in_last) begin
					last_cnt_q <= last_cnt_q + 1'b1;
				end
			end
			if (out_beat) begin
				out_cnt_q <= out_cnt_q + 1'b1;
				if (out_done) begin
					done_cnt_q <= done_cnt_q + 1'b1;
				end
			end
		end
	end

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_cells) && $stable(out_done))
		else $error("result changed while stalled");

	// No live cell outside the grid width
	a_out_masked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_cells & ~live_mask) == '0))
		else $error("live cell beyond grid width");

	// Never more results than rows taken
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> (out_cnt_q < in_cnt_q))
		else $error("result beat without a matching row");

	// A grid bottom result needs a bottom row taken
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && out_done |-> (done_cnt_q < last_cnt_q))
		else $error("grid_done without a bottom row");

endmodule

bind life_generation_row_engine_unit lgre_checker u_lgre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (row_in.valid),
	.in_ready  (row_in.ready),
	.in_last   (row_in.last_row),
	.out_valid (row_out.valid),
	.out_ready (row_out.ready),
	.out_cells (row_out.next_row_cells),
	.out_done  (row_out.grid_done),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.cfg_width (cfg.grid_width)
);

// ===== verif/tb_life_generation_row_engine_unit.sv =====
// Testbench for the Life row engine: directed and random grids checked against a B3/S23 row predictor.
module tb_life_generation_row_engine_unit;

	typedef lgre_pkg::row_t    row_t;
	typedef lgre_pkg::grid_w_t grid_w_t;

	// One next-generation row as it should leave the block
	typedef struct {
		row_t cells;
		logic done;
	} gen_row_t;

	localparam int      HALF_PERIOD     = 10;
	localparam int      MAX_WIDTH       = 64;
	localparam int      RESET_CYCLES    = 9;
	localparam int      SETTLE_CYCLES   = 8;
	localparam int      ROWS_PER_PHASE  = 500;
	localparam int      RECONFIG_EVERY  = 120;
	localparam longint WATCHDOG_TIME   = 64'd8_000_000;

	logic clk = 1'b0;
	logic arst_n;

	lgre_row_in_if  row_in ();
	lgre_row_out_if row_out ();
	lgre_cfg_if     cfg ();

	life_generation_row_engine_unit #(.MAX_WIDTH(MAX_WIDTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.row_in (row_in),
		.row_out(row_out),
		.cfg    (cfg)
	);

	// Predictor state: width register and the two held rows of the current grid
	grid_w_t  width_reg   = grid_w_t'(64);
	row_t     held_above  = '0;
	row_t     held_middle = '0;
	int       held_count  = 0;
	gen_row_t expected_gen_rows[$];

	int mismatch_count = 0;
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;

	always #HALF_PERIOD clk = ~clk;

	// Cells in use for a given width, clamped to MAX_WIDTH
	function automatic row_t cells_in_use(input grid_w_t w);
		if (w >= MAX_WIDTH) begin
			return '1;
		end
		return (row_t'(1) << w) - row_t'(1);
	endfunction

	// B3/S23 applied to the middle row; cells outside the row are dead
	function automatic row_t life_generation(input row_t up, input row_t mid, input row_t down,
			input row_t mask);
		row_t res;
		int   n;
		res = '0;
		for (int j = 0; j < MAX_WIDTH; j++) begin
			n = 0;
			for (int k = j - 1; k <= j + 1; k++) begin
				if (k >= 0 && k < MAX_WIDTH) begin
					n += int'(up[k]) + int'(down[k]);
					if (k != j) begin
						n += int'(mid[k]);
					end
				end
			end
			res[j] = (n == 3) || (mid[j] && n == 2);
		end
		return res & mask;
	endfunction

	// Update held rows for one accepted row and queue the rows it yields
	task automatic predict_gen_rows(input row_t cells, input logic is_bottom);
		row_t     mask;
		row_t     cur;
		gen_row_t gen;
		mask = cells_in_use(width_reg);
		cur  = cells & mask;
		if (held_count == 0) begin
			if (is_bottom) begin
				gen.cells = life_generation('0, cur, '0, mask);
				gen.done  = 1'b1;
				expected_gen_rows.push_back(gen);
			end else begin
				held_above  = '0;
				held_middle = cur;
				held_count  = 1;
			end
		end else begin
			gen.cells = life_generation(held_above, held_middle, cur, mask);
			gen.done  = 1'b0;
			expected_gen_rows.push_back(gen);
			if (is_bottom) begin
				gen.cells = life_generation(held_middle, cur, '0, mask);
				gen.done  = 1'b1;
				expected_gen_rows.push_back(gen);
				held_above  = '0;
				held_middle = '0;
				held_count  = 0;
			end else begin
				held_above  = held_middle;
				held_middle = cur;
				held_count  = 2;
			end
		end
	endtask

	// Send one row beat, with random gaps ahead of it; valid stays high afterwards
	task automatic send_row(input row_t cells, input logic is_bottom);
		while ($urandom_range(99) < send_gap_pct) begin
			row_in.valid <= 1'b0;
			@(posedge clk);
		end
		row_in.valid     <= 1'b1;
		row_in.row_cells <= cells;
		row_in.last_row  <= is_bottom;
		do @(posedge clk); while (!row_in.ready);
		predict_gen_rows(cells, is_bottom);
	endtask

	// Hold off input until every expected row is out, then let the pipe empty
	task automatic settle_block();
		row_in.valid <= 1'b0;
		while (expected_gen_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Width register write, only once the block is idle
	task automatic reconfigure(input grid_w_t w);
		settle_block();
		cfg.valid      <= 1'b1;
		cfg.grid_width <= w;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		width_reg = w;
	endtask

	function automatic row_t random_cells();
		row_t a;
		row_t b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1:    return a & b & {$urandom, $urandom};
			2, 3:    return a | b;
			4:       return $urandom_range(1) ? '1 : '0;
			default: return a;
		endcase
	endfunction

	function automatic grid_w_t random_width();
		case ($urandom_range(9))
			0:       return grid_w_t'($urandom_range(127));
			1:       return grid_w_t'(64);
			2:       return grid_w_t'(1);
			default: return grid_w_t'($urandom_range(1, 64));
		endcase
	endfunction

	// A blinker, solid and checkerboard rows, edge cells and tiny grids at full width
	task automatic test_directed_patterns();
		send_row('1, 1'b1);
		send_row('0, 1'b1);
		// blinker
		send_row('0, 1'b0);
		send_row(row_t'(64'h1C), 1'b0);
		send_row('0, 1'b1);
		// solid block, edges die or survive
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		// corner cells only
		send_row(64'h8000_0000_0000_0001, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b1);
		// checkerboard
		send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_row(64'h5555_5555_5555_5555, 1'b0);
		send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_row(64'h5555_5555_5555_5555, 1'b1);
		// two-row grid
		send_row('1, 1'b0);
		send_row('1, 1'b1);
	endtask

	// Narrow, zero and oversized widths with bits set above the width
	task automatic test_width_extremes();
		grid_w_t widths[4] = '{grid_w_t'(1), grid_w_t'(0), grid_w_t'(127), grid_w_t'(3)};
		foreach (widths[i]) begin
			reconfigure(widths[i]);
			send_row('1, 1'b0);
			send_row(random_cells(), 1'b1);
		end
	endtask

	// Held rows keep the width they came in with; results take the current one
	task automatic test_width_change_mid_grid();
		reconfigure(grid_w_t'(64));
		send_row('1, 1'b0);
		reconfigure(grid_w_t'(5));
		send_row('1, 1'b0);
		reconfigure(grid_w_t'(64));
		send_row('1, 1'b1);
	endtask

	// Random grids of mostly short height, with idle pauses and width changes
	task automatic test_random_grids(input int gap_pct, input int stall_pct);
		int sent;
		int height;
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		reconfigure(random_width());
		while (sent < ROWS_PER_PHASE) begin
			height = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
			for (int r = 0; r < height; r++) begin
				send_row(random_cells(), r == height - 1);
				sent++;
				if (sent % RECONFIG_EVERY == 0) begin
					reconfigure(random_width());
				end
			end
		end
	endtask

	// Result side: random stalls, compare each beat with the oldest expectation
	always @(posedge clk) begin : check_gen_rows
		gen_row_t want;
		row_out.ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && row_out.valid && row_out.ready) begin
			if (expected_gen_rows.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result beat: next_row_cells %h grid_done %b",
						row_out.next_row_cells, row_out.grid_done);
				end
			end else begin
				want = expected_gen_rows.pop_front();
				if (row_out.next_row_cells !== want.cells || row_out.grid_done !== want.done) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: next_row_cells exp %h got %h, grid_done exp %b got %b",
							want.cells, row_out.next_row_cells, want.done, row_out.grid_done);
					end
				end
			end
		end
	end

	initial begin
		arst_n           <= 1'b0;
		row_in.valid     <= 1'b0;
		row_in.row_cells <= '0;
		row_in.last_row  <= 1'b0;
		cfg.valid        <= 1'b0;
		cfg.grid_width   <= grid_w_t'(64);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_patterns();
		test_width_extremes();
		test_width_change_mid_grid();
		test_random_grids(8, 51);
		test_random_grids(51, 8);
		test_random_grids(0, 0);

		settle_block();
		if (mismatch_count == 0 && expected_gen_rows.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(WATCHDOG_TIME);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== life_generation_row_engine_unit.f =====
rtl/lgre_pkg.sv
rtl/lgre_if.sv
rtl/lgre_front.sv
rtl/lgre_queue.sv
rtl/lgre_back.sv
rtl/life_generation_row_engine_unit.sv
rtl/lgre_checker.sv
verif/tb_life_generation_row_engine_unit.sv
